// ----- hw/rtl/phnbf_pkg.sv -----
// ----------------------------------------------------------------------------
// phnbf_pkg: shared types and constants of the page heap allocator
// Holds the page geometry, the request and result structs and status codes.
// ----------------------------------------------------------------------------
package phnbf_pkg;

  localparam int HEAP_PAGES = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PAGE_W = $clog2(HEAP_PAGES);
  localparam int CNT_W = $clog2(HEAP_PAGES + 1);
  localparam int LEN_W = 20;
  localparam int ENTRY_W = LEN_W + 1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  localparam logic CFG_FIT_STRATEGY = 1'b0;
  localparam logic CFG_HEAP_BASE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [22:0] size_bytes;
    logic [31:0] address;
  } phnbf_req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } phnbf_res_t;

  // Page map port: one write and one read per cycle.
  typedef struct packed {
    logic               we;
    logic [PAGE_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [PAGE_W-1:0]  raddr;
  } phnbf_map_cmd_t;

endpackage

// ----- hw/rtl/phnbf_page_map.sv -----
// ----------------------------------------------------------------------------
// phnbf_page_map: page map storage
// One entry per page: used bit and run length, registered read.
// ----------------------------------------------------------------------------
module phnbf_page_map
  import phnbf_pkg::*;
(
  input  logic               clk,
  input  phnbf_map_cmd_t     cmd,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [HEAP_PAGES];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rdata <= mem[cmd.raddr];
  end

endmodule

// ----- hw/rtl/page_heap_next_best_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// page_heap_next_best_fit_allocator: next fit or best fit page allocator
// Scans the page map one entry a cycle under a small sequencer.
// ----------------------------------------------------------------------------
// After reset a clearing pass frees every page; no request is taken
// meanwhile. An allocation scans the page map through its one read port,
// a page a cycle, in one pass in best fit and in up to two passes in next
// fit, then marks the n pages found. A free reads the head entry and erases
// its run. One request is in flight at a time.
module page_heap_next_best_fit_allocator
  import phnbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  phnbf_req_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output phnbf_res_t  out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_SCAN2, S_FREE_RD, S_FREE_CHK, S_MARK,
    S_ERASE, S_DONE
  } state_t;

  state_t             state_r;
  logic               fit_r;
  logic [31:0]        base_r;
  logic [CNT_W-1:0]   ptr_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   limit_r;
  logic               seen_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   need_r;
  logic [CNT_W-1:0]   best_r;
  logic [CNT_W-1:0]   start_r;
  logic               found_r;
  logic               rd_ok_r;
  logic [CNT_W-1:0]   wp_r;
  logic [CNT_W-1:0]   end_r;
  logic               first_r;
  logic               out_valid_r;
  phnbf_res_t         res_r;
  phnbf_map_cmd_t     cmd;
  logic [ENTRY_W-1:0] rdata;
  logic [CNT_W-1:0]   idx_d_r;

  phnbf_page_map u_map (.clk(clk), .cmd(cmd), .rdata(rdata));

  // Request decode: page count and free offset.
  logic [23:0] pages_w;
  logic [31:0] off_w;
  logic [10:0] pages_hi;
  assign pages_w = ({1'b0, in_data.size_bytes} + 24'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
  assign pages_hi = pages_w[23:13];
  assign off_w = in_data.address - base_r;

  logic used_w, cnt_inc_hit;
  logic [CNT_W-1:0] cnt_step;
  assign used_w = rdata[ENTRY_W-1];
  assign cnt_step = used_w ? '0 : cnt_r + 1'b1;
  assign cnt_inc_hit = (cnt_step == need_r);

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = res_r;

  // Map port: reads follow the scan index, writes clear or mark.
  always_comb begin
    cmd = '0;
    cmd.raddr = idx_r[PAGE_W-1:0];
    unique case (state_r)
      S_CLEAR: begin
        cmd.we = 1'b1;
        cmd.waddr = idx_r[PAGE_W-1:0];
      end
      S_MARK: begin
        cmd.we = 1'b1;
        cmd.waddr = wp_r[PAGE_W-1:0];
        cmd.wdata = {1'b1, first_r ? LEN_W'(need_r) : LEN_W'(0)};
      end
      S_ERASE: begin
        cmd.we = 1'b1;
        cmd.waddr = wp_r[PAGE_W-1:0];
      end
      default: ;
    endcase
  end

  // Sequencer. The map read is registered: rd_ok_r marks valid data for
  // the page at idx_d_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      fit_r <= 1'b0;
      base_r <= 32'h8000_0000;
      ptr_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_STRATEGY) fit_r <= cfg_wdata[0];
        else base_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      idx_d_r <= idx_r;
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == CNT_W'(HEAP_PAGES - 1)) begin
            state_r <= S_IDLE;
            idx_r <= '0;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            res_r.result_address <= '0;
            cnt_r <= '0;
            found_r <= 1'b0;
            seen_r <= 1'b0;
            limit_r <= ptr_r;
            need_r <= CNT_W'(pages_w);
            if (in_data.mode == MODE_FREE) begin
              if (off_w[PAGE_SHIFT-1:0] != '0 ||
                  (off_w >> PAGE_SHIFT) >= 32'(HEAP_PAGES)) begin
                res_r.status <= ST_BAD_ADDR;
                state_r <= S_DONE;
              end else begin
                res_r.status <= ST_OK;
                idx_r <= CNT_W'(off_w >> PAGE_SHIFT);
                state_r <= S_FREE_RD;
              end
            end else if (pages_w == '0 || pages_w > 24'(HEAP_PAGES) ||
                         pages_hi != '0) begin
              res_r.status <= ST_BAD_SIZE;
              state_r <= S_DONE;
            end else begin
              res_r.status <= ST_OK;
              idx_r <= fit_r ? '0 : ptr_r;
              rd_ok_r <= 1'b0;
              state_r <= S_SCAN;
            end
          end
        end
        S_FREE_RD: state_r <= S_FREE_CHK;
        S_FREE_CHK: begin
          if (!used_w || rdata[LEN_W-1:0] == '0) begin
            res_r.status <= ST_BAD_ADDR;
            state_r <= S_DONE;
          end else begin
            wp_r <= idx_r;
            end_r <= (21'(idx_r) + 21'(rdata[LEN_W-1:0]) > 21'(HEAP_PAGES)) ?
                     CNT_W'(HEAP_PAGES) : CNT_W'(21'(idx_r) + 21'(rdata[LEN_W-1:0]));
            state_r <= S_ERASE;
          end
        end
        S_ERASE: begin
          wp_r <= wp_r + 1'b1;
          if (wp_r + 1'b1 == end_r) state_r <= S_DONE;
        end
        S_SCAN: begin
          // Issue reads up to the heap end; process each page's data in the cycle after its read.
          if (idx_r < CNT_W'(HEAP_PAGES)) idx_r <= idx_r + 1'b1;
          rd_ok_r <= idx_r < CNT_W'(HEAP_PAGES);
          if (fit_r) begin
            if (rd_ok_r && !used_w) begin
              cnt_r <= cnt_r + 1'b1;
            end else if (rd_ok_r || idx_r == CNT_W'(HEAP_PAGES)) begin
              if (cnt_r >= need_r && (!found_r || cnt_r < best_r)) begin
                best_r <= cnt_r;
                start_r <= idx_d_r - cnt_r;
                found_r <= 1'b1;
              end
              cnt_r <= '0;
              if (!rd_ok_r) state_r <= S_SCAN2;
            end
          end else if (rd_ok_r) begin
            cnt_r <= cnt_step;
            if (used_w && !seen_r) begin
              limit_r <= idx_d_r;
              seen_r <= 1'b1;
            end
            if (cnt_inc_hit) begin
              start_r <= idx_d_r + 1'b1 - need_r;
              found_r <= 1'b1;
              state_r <= S_SCAN2;
            end
          end else if (idx_r == CNT_W'(HEAP_PAGES)) begin
            // Second pass from the heap start.
            idx_r <= '0;
            cnt_r <= '0;
            state_r <= S_SCAN2;
            found_r <= 1'b0;
            best_r <= '1;
          end
        end
        S_SCAN2: begin
          if (fit_r || found_r) begin
            // Scan finished: commit or report.
            if (found_r) begin
              wp_r <= start_r;
              first_r <= 1'b1;
              end_r <= start_r + need_r;
              state_r <= S_MARK;
            end else begin
              res_r.status <= ST_NO_SPACE;
              state_r <= S_DONE;
            end
          end else begin
            if (idx_r < limit_r) idx_r <= idx_r + 1'b1;
            rd_ok_r <= idx_r < limit_r;
            if (rd_ok_r) begin
              cnt_r <= cnt_step;
              if (cnt_inc_hit) begin
                start_r <= idx_d_r + 1'b1 - need_r;
                found_r <= 1'b1;
              end
            end else if (best_r == '0) begin
              res_r.status <= ST_NO_SPACE;
              state_r <= S_DONE;
            end
            best_r <= '0;
          end
        end
        S_MARK: begin
          first_r <= 1'b0;
          wp_r <= wp_r + 1'b1;
          if (wp_r + 1'b1 == end_r) begin
            ptr_r <= end_r;
            res_r.result_address <= base_r + (32'(start_r) << PAGE_SHIFT);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A request is only taken while no result waits.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("request taken while result waits");
  // The pointer never passes the heap end.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= CNT_W'(HEAP_PAGES)) else $error("pointer out of range");
  // A result follows the done state.
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid_r) else $error("result lost");
  // Failed results carry a zero address.
  a_ok_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status != ST_OK) |-> res_r.result_address == '0)
    else $error("failed result has address");

endmodule
